// File: sv/iirdf1_pkg.sv
// Shared types and constants for the direct-form I IIR filter.
package iirdf1_pkg;

   localparam int FILTER_ORDER   = 3;
   localparam int HIST_DEPTH     = 3;
   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_WIDTH     = 16;
   localparam int COEF_FRAC_BITS = 14;
   localparam int NUM_REGS       = 7;
   localparam int REG_IDX_WIDTH  = 3;

   // products of a sample and a coefficient, and the accumulator with headroom for seven terms
   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 4;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic [REG_IDX_WIDTH-1:0]       reg_idx_type;

   localparam reg_idx_type REG_COEF_B0 = 3'd0;
   localparam reg_idx_type REG_COEF_B1 = 3'd1;
   localparam reg_idx_type REG_COEF_B2 = 3'd2;
   localparam reg_idx_type REG_COEF_B3 = 3'd3;
   localparam reg_idx_type REG_COEF_A1 = 3'd4;
   localparam reg_idx_type REG_COEF_A2 = 3'd5;
   localparam reg_idx_type REG_COEF_A3 = 3'd6;

   localparam coef_type COEF_B0_RESET = coef_type'(1 << COEF_FRAC_BITS);

endpackage

// File: sv/iir_direct_form_one_filter.sv
// Direct-form I IIR filter, third order, Q2.14 coefficients, rounded and saturated output.
//
// One sample per clock cycle sustained while rsp_ready holds. An accepted word lands in an
// input register; from there all seven products, the sum, rounding and saturation are formed
// in one pass and load the result register once it is free. The rate is set by the recursion
// through the output history: each result must be final before the following sample's sum can
// be formed. The result register lets a new sample in while the previous result waits for
// rsp_ready. block_start zeroes both histories ahead of its sample. Coefficients are written
// through csr_write/csr_index/csr_data, by the user only while idle; the block does not check.
module iir_direct_form_one_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  iirdf1_pkg::sample_type      req_sample_in,
   input  logic                        req_block_start,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output iirdf1_pkg::sample_type      rsp_sample_out,
   output logic                        rsp_clipped,
   input  logic                        csr_write,
   input  iirdf1_pkg::reg_idx_type     csr_index,
   input  iirdf1_pkg::coef_type        csr_data
);

   localparam int ACC_WIDTH = iirdf1_pkg::ACC_WIDTH;
   localparam int HD        = iirdf1_pkg::HIST_DEPTH;
   localparam logic signed [ACC_WIDTH-1:0] SAT_MAX =
      ACC_WIDTH'((2 ** (iirdf1_pkg::SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [ACC_WIDTH-1:0] SAT_MIN =
      ACC_WIDTH'(-(2 ** (iirdf1_pkg::SAMPLE_WIDTH - 1)));
   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
      ACC_WIDTH'(1 << (iirdf1_pkg::COEF_FRAC_BITS - 1));

   // coefficients
   iirdf1_pkg::coef_type coef_b_ff [0:HD];
   iirdf1_pkg::coef_type coef_a_ff [1:HD];

   // input stage
   logic                   in_valid_ff;
   iirdf1_pkg::sample_type in_sample_ff;
   logic                   in_start_ff;

   // histories
   iirdf1_pkg::sample_type in_hist_ff  [0:HD-1];
   iirdf1_pkg::sample_type out_hist_ff [0:HD-1];

   // result stage
   logic                   out_valid_ff, out_valid_in;
   iirdf1_pkg::sample_type out_sample_ff;
   logic                   out_clip_ff;

   logic                   advance;
   iirdf1_pkg::sample_type hx [0:HD-1];
   iirdf1_pkg::sample_type hy [0:HD-1];
   logic signed [iirdf1_pkg::PROD_WIDTH-1:0] prod_b [0:HD];
   logic signed [iirdf1_pkg::PROD_WIDTH-1:0] prod_a [1:HD];
   logic signed [ACC_WIDTH-1:0] acc;
   logic signed [ACC_WIDTH-1:0] rnd;
   iirdf1_pkg::sample_type      result;
   logic                        clip;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b_ff[0] <= iirdf1_pkg::COEF_B0_RESET;
         for (int k = 1; k <= HD; k++) begin
            coef_b_ff[k] <= '0;
            coef_a_ff[k] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            iirdf1_pkg::REG_COEF_B0: coef_b_ff[0] <= csr_data;
            iirdf1_pkg::REG_COEF_B1: coef_b_ff[1] <= csr_data;
            iirdf1_pkg::REG_COEF_B2: coef_b_ff[2] <= csr_data;
            iirdf1_pkg::REG_COEF_B3: coef_b_ff[3] <= csr_data;
            iirdf1_pkg::REG_COEF_A1: coef_a_ff[1] <= csr_data;
            iirdf1_pkg::REG_COEF_A2: coef_a_ff[2] <= csr_data;
            iirdf1_pkg::REG_COEF_A3: coef_a_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= req_sample_in;
         in_start_ff  <= req_block_start;
      end
   end

   // datapath: a start word sees zero histories
   always_comb begin
      for (int k = 0; k < HD; k++) begin
         hx[k] = in_start_ff ? '0 : in_hist_ff[k];
         hy[k] = in_start_ff ? '0 : out_hist_ff[k];
      end
      prod_b[0] = coef_b_ff[0] * in_sample_ff;
      for (int k = 1; k <= HD; k++) begin
         if (k <= iirdf1_pkg::FILTER_ORDER) begin
            prod_b[k] = coef_b_ff[k] * hx[k-1];
            prod_a[k] = coef_a_ff[k] * hy[k-1];
         end else begin
            prod_b[k] = '0;
            prod_a[k] = '0;
         end
      end
      acc = ACC_WIDTH'(prod_b[0]);
      for (int k = 1; k <= HD; k++) begin
         acc = acc + ACC_WIDTH'(prod_b[k]) - ACC_WIDTH'(prod_a[k]);
      end
      // round half up, then floor shift
      rnd = (acc + ROUND_HALF) >>> iirdf1_pkg::COEF_FRAC_BITS;
      if (rnd > SAT_MAX) begin
         result = iirdf1_pkg::sample_type'(SAT_MAX);
         clip   = 1'b1;
      end else if (rnd < SAT_MIN) begin
         result = iirdf1_pkg::sample_type'(SAT_MIN);
         clip   = 1'b1;
      end else begin
         result = iirdf1_pkg::sample_type'(rnd);
         clip   = 1'b0;
      end
   end

   // advance histories as the word moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HD; k++) begin
            in_hist_ff[k]  <= '0;
            out_hist_ff[k] <= '0;
         end
      end else if (advance) begin
         in_hist_ff[0]  <= in_sample_ff;
         out_hist_ff[0] <= result;
         for (int k = 1; k < HD; k++) begin
            in_hist_ff[k]  <= hx[k-1];
            out_hist_ff[k] <= hy[k-1];
         end
      end
   end

   // result register
   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_sample_ff <= result;
         out_clip_ff   <= clip;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_clipped    = out_clip_ff;

   a_clip_at_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_sample_out == iirdf1_pkg::sample_type'(SAT_MAX) ||
          rsp_sample_out == iirdf1_pkg::sample_type'(SAT_MIN)))
      else $error("clipped result is not at a saturation bound");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("word left the input stage without a result");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("input stalled while result register is empty");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_start_ff) |=> (in_hist_ff[1] == '0 && out_hist_ff[1] == '0))
      else $error("block start did not clear the histories");

   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      advance |=> (in_hist_ff[0] == $past(in_sample_ff) && out_hist_ff[0] == rsp_sample_out))
      else $error("histories not loaded with the current word");

endmodule
